[rtl/core/counting_semaphore_fifo_waiters_macros.svh]
// Assertion macros shared by the semaphore RTL.
// No dependencies; included by the files that carry assertions.
`ifndef COUNTING_SEMAPHORE_FIFO_WAITERS_MACROS_SVH
`define COUNTING_SEMAPHORE_FIFO_WAITERS_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define CSFW_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CSFW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/csfw_pkg.sv]
// Types, codes and command/status structs for the counting semaphore.
// No dependencies; used by csfw_ctrl, csfw_dp and the top level.
`timescale 1ns / 1ps

package csfw_pkg;

  localparam int COUNT_W = 18;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef logic [1:0] func_t;
  typedef logic [2:0] status_t;

  localparam func_t FUNC_WAIT   = 2'd0;
  localparam func_t FUNC_SIGNAL = 2'd1;
  localparam func_t FUNC_CLOSE  = 2'd2;
  localparam func_t FUNC_NONE   = 2'd3;

  localparam status_t ST_GRANTED    = 3'd0;
  localparam status_t ST_BLOCKED    = 3'd1;
  localparam status_t ST_REL_OK     = 3'd2;
  localparam status_t ST_REL_CLOSED = 3'd3;
  localparam status_t ST_REF_CLOSED = 3'd4;
  localparam status_t ST_REF_FULL   = 3'd5;
  localparam status_t ST_DONE       = 3'd6;

  // controller -> datapath
  typedef struct packed {
    logic    load_req;
    logic    emit;
    logic    sel_waiter;
    status_t code;
    logic    last;
    logic    dec_count;
    logic    inc_count;
    logic    push;
    logic    pop;
    logic    set_closed;
    logic    clear_queue;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    func_t func;
    logic  closed;
    logic  count_zero;
    logic  count_full;
    logic  q_empty;
    logic  q_full;
    logic  out_free;
  } sts_t;

endpackage

[rtl/core/csfw_dp.sv]
// Datapath: request latch, count, closed flag, waiter queue memory, result register.
// Depends on csfw_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "counting_semaphore_fifo_waiters_macros.svh"

module csfw_dp #(
  parameter int QUEUE_DEPTH    = 16,
  parameter int THREAD_ID_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [15:0]               cfg_wr_data,
  input  csfw_pkg::func_t           in_func,
  input  logic [THREAD_ID_BITS-1:0] in_thread_id,
  input  csfw_pkg::cmd_t            cmd,
  output csfw_pkg::sts_t            sts,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [THREAD_ID_BITS-1:0] out_thread_id_res,
  output csfw_pkg::status_t         out_status,
  output logic                      out_last
);
  import csfw_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int WCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [WCNT_W-1:0] WCNT_FULL = WCNT_W'(QUEUE_DEPTH);

  func_t                     req_func_r;
  logic [THREAD_ID_BITS-1:0] req_tid_r;
  logic [COUNT_W-1:0]        count_r;
  logic                      closed_r;
  logic [PTR_W-1:0]          head_r;
  logic [PTR_W-1:0]          tail_r;
  logic [WCNT_W-1:0]         wcnt_r;
  logic [THREAD_ID_BITS-1:0] mem [QUEUE_DEPTH];
  logic [THREAD_ID_BITS-1:0] rd_data_r;
  logic                      out_valid_r;
  logic [THREAD_ID_BITS-1:0] tid_res_r;
  status_t                   status_r;
  logic                      last_r;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_func_r <= in_func;
      req_tid_r  <= in_thread_id;
    end
  end

  // waiter queue: one write port at the tail, registered read at the head
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail_r] <= req_tid_r;
    end
    rd_data_r <= mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      closed_r <= 1'b0;
      head_r   <= '0;
      tail_r   <= '0;
      wcnt_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        count_r <= COUNT_W'(cfg_wr_data);
      end else if (cmd.dec_count) begin
        count_r <= count_r - COUNT_W'(1);
      end else if (cmd.inc_count) begin
        count_r <= count_r + COUNT_W'(1);
      end
      if (cmd.set_closed) begin
        closed_r <= 1'b1;
      end
      if (cmd.clear_queue) begin
        head_r <= '0;
        tail_r <= '0;
        wcnt_r <= '0;
      end else begin
        if (cmd.push) begin
          tail_r <= (tail_r == PTR_LAST) ? '0 : tail_r + PTR_W'(1);
        end
        if (cmd.pop) begin
          head_r <= (head_r == PTR_LAST) ? '0 : head_r + PTR_W'(1);
        end
        if (cmd.push && !cmd.pop) begin
          wcnt_r <= wcnt_r + WCNT_W'(1);
        end else if (cmd.pop && !cmd.push) begin
          wcnt_r <= wcnt_r - WCNT_W'(1);
        end
      end
    end
  end

  // result register; refilled only once empty so the head read has settled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      tid_res_r <= cmd.sel_waiter ? rd_data_r : req_tid_r;
      status_r  <= cmd.code;
      last_r    <= cmd.last;
    end
  end

  always_comb begin
    sts.func       = req_func_r;
    sts.closed     = closed_r;
    sts.count_zero = (count_r == '0);
    sts.count_full = (count_r == COUNT_MAX);
    sts.q_empty    = (wcnt_r == '0);
    sts.q_full     = (wcnt_r >= WCNT_FULL);
    sts.out_free   = !out_valid_r;
  end

  assign out_valid         = out_valid_r;
  assign out_thread_id_res = tid_res_r;
  assign out_status        = status_r;
  assign out_last          = last_r;

  `CSFW_ASSERT_IMPL(a_empty_ptrs, wcnt_r == '0, head_r == tail_r, "empty queue with split pointers")
  `CSFW_ASSERT_IMPL(a_no_push_full, cmd.push, wcnt_r < WCNT_FULL, "push into full queue")
  `CSFW_ASSERT_IMPL(a_no_pop_empty, cmd.pop, wcnt_r != '0, "pop from empty queue")
  `CSFW_ASSERT_IMPL(a_emit_free, cmd.emit, !out_valid_r, "result overwritten before taken")
  `CSFW_ASSERT_NEXT(a_closed_sticky, closed_r, closed_r, "closed flag cleared")

endmodule

[rtl/core/csfw_ctrl.sv]
// Controller state machine: sequences each request into datapath commands.
// Depends on csfw_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "counting_semaphore_fifo_waiters_macros.svh"

module csfw_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  csfw_pkg::sts_t sts,
  output csfw_pkg::cmd_t cmd
);
  import csfw_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECIDE = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_FINAL  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.func == FUNC_NONE) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          state_nxt = S_IDLE;
          if (sts.closed) begin
            cmd.emit = 1'b1;
            cmd.code = ST_REF_CLOSED;
            cmd.last = 1'b1;
          end else begin
            unique case (sts.func)
              FUNC_WAIT: begin
                cmd.emit = 1'b1;
                cmd.last = 1'b1;
                if (!sts.count_zero) begin
                  cmd.code      = ST_GRANTED;
                  cmd.dec_count = 1'b1;
                end else if (sts.q_full) begin
                  cmd.code = ST_REF_FULL;
                end else begin
                  cmd.code = ST_BLOCKED;
                  cmd.push = 1'b1;
                end
              end
              FUNC_SIGNAL: begin
                cmd.emit = 1'b1;
                if (!sts.q_empty) begin
                  // hand the unit straight to the oldest waiter
                  cmd.sel_waiter = 1'b1;
                  cmd.code       = ST_REL_OK;
                  cmd.pop        = 1'b1;
                  state_nxt      = S_FINAL;
                end else if (sts.count_full) begin
                  cmd.code = ST_REF_FULL;
                  cmd.last = 1'b1;
                end else begin
                  cmd.code      = ST_DONE;
                  cmd.last      = 1'b1;
                  cmd.inc_count = 1'b1;
                end
              end
              FUNC_CLOSE: begin
                cmd.set_closed = 1'b1;
                state_nxt      = S_DRAIN;
              end
              default: begin
                state_nxt = S_IDLE;
              end
            endcase
          end
        end
      end
      S_DRAIN: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (!sts.q_empty) begin
            cmd.sel_waiter = 1'b1;
            cmd.code       = ST_REL_CLOSED;
            cmd.pop        = 1'b1;
          end else begin
            cmd.code        = ST_DONE;
            cmd.last        = 1'b1;
            cmd.clear_queue = 1'b1;
            state_nxt       = S_IDLE;
          end
        end
      end
      S_FINAL: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.code  = ST_DONE;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `CSFW_ASSERT_IMPL(a_load_idle, cmd.load_req, state_r == S_IDLE, "request loaded outside idle")
  `CSFW_ASSERT_IMPL(a_emit_free, cmd.emit, sts.out_free, "emit while result register busy")
  `CSFW_ASSERT_NEXT(a_load_decide, cmd.load_req, state_r == S_DECIDE, "loaded request not decoded")

endmodule

[rtl/core/counting_semaphore_fifo_waiters.sv]
// Channel   Ports                                        Handshake
// in        in_func, in_thread_id                        in_valid / in_stall
// out       out_thread_id_res, out_status, out_last      out_valid / out_stall
// cfg       cfg_wr_data (initial_count)                  cfg_wr_en, no wait
//
// One request at a time: accept, decode, then each result passes through the
// single result register (load, then taken); a close releases every waiter in
// queue order and then gives a final done result.
// The result register is refilled only once empty, which also lets the
// registered queue read at the head settle after each release.
// Synchronous active-low reset clears the count, closed flag and queue pointers.
`timescale 1ns / 1ps

module counting_semaphore_fifo_waiters #(
  parameter int QUEUE_DEPTH    = 16,
  parameter int THREAD_ID_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [15:0]               cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  csfw_pkg::func_t           in_func,
  input  logic [THREAD_ID_BITS-1:0] in_thread_id,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [THREAD_ID_BITS-1:0] out_thread_id_res,
  output csfw_pkg::status_t         out_status,
  output logic                      out_last
);
  import csfw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  csfw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  csfw_dp #(
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .THREAD_ID_BITS (THREAD_ID_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_func           (in_func),
    .in_thread_id      (in_thread_id),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_thread_id_res (out_thread_id_res),
    .out_status        (out_status),
    .out_last          (out_last)
  );

endmodule
